/* sv/address_match_mask_table_unit_assert.svh */
// Assertion macros for the address match mask table unit.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef ADDRESS_MATCH_MASK_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_MATCH_MASK_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AMMT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AMMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ammt_pkg.sv */
// Package for the address match mask table unit: sizes, command codes and
// the transaction token that travels along the cell chain. No dependencies.
`default_nettype none

package ammt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int COUNT_WIDTH   = $clog2(TABLE_ENTRIES + 1);
   localparam int CMD_WIDTH     = 2;
   localparam int ADDR_WIDTH    = 32;
   localparam int BITS_WIDTH    = 9;
   localparam int USED_WIDTH    = 5;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef struct packed {
      logic                   live;
      cmd_type                cmd;
      logic [ADDR_WIDTH-1:0]  address;
      logic [BITS_WIDTH-1:0]  hook_bits;
      logic [BITS_WIDTH-1:0]  found_bits;
      logic                   hit;
      logic                   placed;
      logic [COUNT_WIDTH-1:0] used;
   } token_type;

endpackage

`default_nettype wire

/* sv/address_match_mask_table_unit.sv */
// Address match mask table unit: a chain of TABLE_ENTRIES cells, one entry each.
// Each transaction passes through the token register of every cell in turn, and its result
// can be taken from the final cell once it has passed through all TABLE_ENTRIES cells.
// Throughput: one transaction per cycle; the chain holds only while a result waits under
// rsp_stall, and the final cell's token register is the output register.
// Synchronous reset empties the table and the chain; entry contents are not cleared.
`default_nettype none

module address_match_mask_table_unit import ammt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_WIDTH-1:0]  req_command,
   input  logic [ADDR_WIDTH-1:0] req_address,
   input  logic [BITS_WIDTH-1:0] req_hook_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BITS_WIDTH-1:0] rsp_found_bits,
   output logic                  rsp_hit,
   output logic                  rsp_dropped,
   output logic [USED_WIDTH-1:0] rsp_used_entries
);

   token_type chain [TABLE_ENTRIES+1];
   token_type last_tok;
   logic      advance;

   assign last_tok  = chain[TABLE_ENTRIES];
   assign advance   = !last_tok.live || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      chain[0].live       = req_valid;
      chain[0].cmd        = cmd_type'(req_command);
      chain[0].address    = req_address;
      chain[0].hook_bits  = req_hook_bits;
      chain[0].found_bits = '0;
      chain[0].hit        = 1'b0;
      chain[0].placed     = 1'b0;
      chain[0].used       = '0;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ammt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .prev_tok (chain[i]),
         .next_tok (chain[i+1])
      );
   end

   assign rsp_valid        = last_tok.live;
   assign rsp_found_bits   = last_tok.found_bits;
   assign rsp_hit          = last_tok.hit;
   assign rsp_dropped      = (last_tok.cmd == CMD_ADD) && !last_tok.hit && !last_tok.placed;
   assign rsp_used_entries = USED_WIDTH'(last_tok.used);

endmodule

`default_nettype wire

/* sv/ammt_cell.sv */
// One table cell: holds a single entry and passes the transaction token on.
// Depends on ammt_pkg.
`default_nettype none

module ammt_cell import ammt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  token_type prev_tok,
   output token_type next_tok
);

   logic                  valid_ff, valid_in;
   logic [ADDR_WIDTH-1:0] address_ff, address_in;
   logic [BITS_WIDTH-1:0] bits_ff, bits_in;
   token_type             tok_ff, tok_in;
   logic                  match;

   always_comb begin
      match      = valid_ff && (address_ff == prev_tok.address);
      valid_in   = valid_ff;
      address_in = address_ff;
      bits_in    = bits_ff;
      tok_in     = prev_tok;
      case (prev_tok.cmd)
         CMD_CLEAR: begin
            valid_in = 1'b0;
         end
         CMD_ADD: begin
            if (!prev_tok.hit && match) begin
               bits_in    = bits_ff | prev_tok.hook_bits;
               tok_in.hit = 1'b1;
            end else if (!prev_tok.hit && !prev_tok.placed && !valid_ff) begin
               valid_in      = 1'b1;
               address_in    = prev_tok.address;
               bits_in       = prev_tok.hook_bits;
               tok_in.placed = 1'b1;
            end
         end
         CMD_LOOKUP: begin
            if (match) begin
               tok_in.found_bits = bits_ff;
               tok_in.hit        = 1'b1;
            end
         end
         default: begin
         end
      endcase
      tok_in.used = prev_tok.used + COUNT_WIDTH'(valid_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         tok_ff.live <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
         if (prev_tok.live) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && prev_tok.live) begin
         address_ff <= address_in;
         bits_ff    <= bits_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

`default_nettype wire

/* sv/ammt_checker.sv */
// Port checker for the address match mask table unit, bound to the top level.
// Depends on ammt_pkg and the assertion macro header.
`default_nettype none

`include "address_match_mask_table_unit_assert.svh"

module ammt_checker import ammt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [BITS_WIDTH-1:0] rsp_found_bits,
   input logic                  rsp_hit,
   input logic                  rsp_dropped,
   input logic [USED_WIDTH-1:0] rsp_used_entries
);

   `AMMT_ASSERT_NOW(a_drop_excl, rsp_valid && rsp_dropped,
                    !rsp_hit && rsp_found_bits == '0, "dropped transaction reports a hit or bits")
   `AMMT_ASSERT_NOW(a_drop_full, rsp_valid && rsp_dropped,
                    rsp_used_entries == USED_WIDTH'(TABLE_ENTRIES), "drop while table not full")
   `AMMT_ASSERT_NOW(a_bits_hit, rsp_valid && rsp_found_bits != '0, rsp_hit,
                    "found bits without a hit")
   `AMMT_ASSERT_NOW(a_req_stall, 1'b1, req_stall == (rsp_valid && rsp_stall),
                    "input stall does not follow a waiting result")
   `AMMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_found_bits) && $stable(rsp_used_entries),
                     "stalled response changed")

endmodule

bind address_match_mask_table_unit ammt_checker u_ammt_checker (.*);

`default_nettype wire

/* test/address_match_mask_table_unit_checker.sv */
`timescale 1ns / 100ps
// Checker for the address match mask table unit: it watches both channels, keeps its own
// copy of the table to predict each result and compares results in order.
// Depends on ammt_pkg for sizes and command codes.

module address_match_mask_table_checker import ammt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CMD_WIDTH-1:0]  req_command,
   input  logic [ADDR_WIDTH-1:0] req_address,
   input  logic [BITS_WIDTH-1:0] req_hook_bits,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [BITS_WIDTH-1:0] rsp_found_bits,
   input  logic                  rsp_hit,
   input  logic                  rsp_dropped,
   input  logic [USED_WIDTH-1:0] rsp_used_entries,
   output int                    mismatch_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [BITS_WIDTH-1:0] found_bits;
      logic                  hit;
      logic                  dropped;
      logic [USED_WIDTH-1:0] used_entries;
   } answer_type;

   answer_type            awaited_answers[$];
   logic [ADDR_WIDTH-1:0] shadow_addr [TABLE_ENTRIES];
   logic [BITS_WIDTH-1:0] shadow_bits [TABLE_ENTRIES];
   int                    shadow_count;

   function automatic answer_type apply_command(input logic [CMD_WIDTH-1:0]  cmd,
                                                input logic [ADDR_WIDTH-1:0] addr,
                                                input logic [BITS_WIDTH-1:0] bits);
      answer_type ans;
      int         slot;
      ans = '0;
      slot = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (slot < 0 && shadow_addr[i] == addr) begin
            slot = i;
         end
      end
      case (cmd)
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         CMD_ADD: begin
            if (slot >= 0) begin
               shadow_bits[slot] = shadow_bits[slot] | bits;
               ans.hit = 1'b1;
            end else if (shadow_count >= TABLE_ENTRIES) begin
               ans.dropped = 1'b1;
            end else begin
               shadow_addr[shadow_count] = addr;
               shadow_bits[shadow_count] = bits;
               shadow_count++;
            end
         end
         CMD_LOOKUP: begin
            if (slot >= 0) begin
               ans.found_bits = shadow_bits[slot];
               ans.hit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      ans.used_entries = USED_WIDTH'(shadow_count);
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      answer_type got;
      if (reset) begin
         shadow_count = 0;
         awaited_answers.delete();
      end else begin
         if (req_valid && !req_stall) begin
            awaited_answers.push_back(apply_command(req_command, req_address, req_hook_bits));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_found_bits, rsp_hit, rsp_dropped, rsp_used_entries};
            if (awaited_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected transaction: found_bits %h hit %b dropped %b used %0d",
                           $realtime, got.found_bits, got.hit, got.dropped, got.used_entries);
               end
            end else begin
               want = awaited_answers.pop_front();
               if (got.found_bits !== want.found_bits || got.hit !== want.hit ||
                   got.dropped !== want.dropped || got.used_entries !== want.used_entries) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected found_bits %h hit %b dropped %b used %0d", $realtime,
                              want.found_bits, want.hit, want.dropped, want.used_entries);
                     $display("%0t: actual   found_bits %h hit %b dropped %b used %0d", $realtime,
                              got.found_bits, got.hit, got.dropped, got.used_entries);
                  end
               end
            end
         end
         outstanding = awaited_answers.size();
      end
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Top of the testbench for the address match mask table unit: clock, reset, stimulus and
// verdict. Depends on ammt_pkg, the unit itself and address_match_mask_table_checker.

module tb import ammt_pkg::*;;

   localparam logic [CMD_WIDTH-1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int POOL_SIZE      = 24;
   localparam int SQUEEZE_CYCLES = 100;
   localparam int CYCLE_LIMIT    = 400000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_WIDTH-1:0]  req_command;
   logic [ADDR_WIDTH-1:0] req_address;
   logic [BITS_WIDTH-1:0] req_hook_bits;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BITS_WIDTH-1:0] rsp_found_bits;
   logic                  rsp_hit;
   logic                  rsp_dropped;
   logic [USED_WIDTH-1:0] rsp_used_entries;

   int                    mismatch_count;
   int                    outstanding;
   int                    cycle_count;
   logic                  squeeze_wanted = 1'b0;
   logic                  squeeze_done = 1'b0;
   logic [ADDR_WIDTH-1:0] addr_pool [POOL_SIZE];

   always #5 clock = ~clock;

   address_match_mask_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_hook_bits    (req_hook_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found_bits   (rsp_found_bits),
      .rsp_hit          (rsp_hit),
      .rsp_dropped      (rsp_dropped),
      .rsp_used_entries (rsp_used_entries)
   );

   address_match_mask_table_checker table_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_hook_bits    (req_hook_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found_bits   (rsp_found_bits),
      .rsp_hit          (rsp_hit),
      .rsp_dropped      (rsp_dropped),
      .rsp_used_entries (rsp_used_entries),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [BITS_WIDTH-1:0] pick_bits();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return '0;
      end else if (r < 25) begin
         return '1;
      end
      return BITS_WIDTH'($urandom);
   endfunction

   task automatic offer(input logic [CMD_WIDTH-1:0]  cmd,
                        input logic [ADDR_WIDTH-1:0] addr,
                        input logic [BITS_WIDTH-1:0] bits,
                        input int                    gap);
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_address   <= addr;
      req_hook_bits <= bits;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("address_match_mask_table_unit: mismatch");
         $finish;
      end
   end

   initial begin
      int len;
      int r;
      rsp_stall <= 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (squeeze_wanted && !squeeze_done) begin
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
            rsp_stall <= 1'b0;
            len = $urandom_range(1, 8);
         end else if (r < 10) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(20, 60);
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(1, 6);
         end else if (r < 93) begin
            rsp_stall <= 1'b1;
            len = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            len = $urandom_range(8, 30);
         end
         repeat (len) @(posedge clock);
      end
   end

   initial begin
      logic [CMD_WIDTH-1:0]  cmd;
      logic [ADDR_WIDTH-1:0] addr;
      int                    r;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_command   <= CMD_CLEAR;
      req_address   <= '0;
      req_hook_bits <= '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         addr_pool[i] = $urandom;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      offer(CMD_CLEAR, 32'h0000_0000, 9'h000, pick_gap());
      offer(CMD_LOOKUP, 32'h0000_0000, 9'h1FF, pick_gap());
      offer(CMD_ADD, 32'h0000_0000, 9'h000, pick_gap());
      offer(CMD_ADD, 32'hFFFF_FFFF, 9'h1FF, pick_gap());
      offer(CMD_LOOKUP, 32'h0000_0000, 9'h000, pick_gap());
      offer(CMD_LOOKUP, 32'hFFFF_FFFF, 9'h000, pick_gap());
      offer(CMD_ADD, 32'h0000_0000, 9'h0A5, pick_gap());
      offer(CMD_LOOKUP, 32'h0000_0000, 9'h15A, pick_gap());
      offer(CMD_SPARE, 32'hFFFF_FFFF, 9'h1FF, pick_gap());
      for (int i = 1; i <= TABLE_ENTRIES - 2; i++) begin
         offer(CMD_ADD, (32'(i) << 28) | 32'h0123_4567, BITS_WIDTH'(i * 37), pick_gap());
      end
      offer(CMD_ADD, 32'h8000_0001, 9'h100, pick_gap());
      offer(CMD_ADD, 32'hFFFF_FFFF, 9'h001, pick_gap());
      offer(CMD_CLEAR, 32'hFFFF_FFFF, 9'h1FF, pick_gap());
      offer(CMD_LOOKUP, 32'hFFFF_FFFF, 9'h000, pick_gap());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 999);
         if (r < 12) begin
            cmd = CMD_CLEAR;
         end else if (r < 40) begin
            cmd = CMD_SPARE;
         end else if (r < 470) begin
            cmd = CMD_ADD;
         end else begin
            cmd = CMD_LOOKUP;
         end
         if ($urandom_range(0, 9) == 0) begin
            addr = $urandom;
         end else begin
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         if (n == 300) begin
            squeeze_wanted = 1'b1;
         end
         if ((squeeze_wanted && !squeeze_done) || (n % 250) < 40) begin
            offer(cmd, addr, pick_bits(), 0);
         end else begin
            offer(cmd, addr, pick_bits(), pick_gap());
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * TABLE_ENTRIES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("address_match_mask_table_unit: match");
      end else begin
         $display("address_match_mask_table_unit: mismatch");
      end
      $finish;
   end

endmodule
